@@ hdl/dahdsr_pkg.sv @@
// ----------------------------------------------------------------------------
// DAHDSR envelope package
// Shared widths, phase codes, microcode encoding, the microprogram and the
// small level helpers used by the envelope sequencer and its divider.
// ----------------------------------------------------------------------------
package dahdsr_pkg;

   localparam int LEN_W   = 22;              // phase length and sample counter
   localparam int STEP_W  = 10;              // samples per advance request
   localparam int LVL_W   = 16;              // Q1.15 level
   localparam int Q_W     = 15;              // ramp quotient, always below 1.0
   localparam int PROD_W  = LVL_W + LEN_W;   // ramp numerator
   localparam int CNT_W   = $clog2(Q_W + 1); // divider bit counter
   localparam int CODE_W  = 8;               // sustain code
   localparam int IDX_W   = 3;               // register index
   localparam int UPC_W   = 4;               // microprogram address

   localparam logic [LVL_W-1:0] FULL_SCALE = 16'h8000;

   // Envelope phases.
   localparam logic [2:0] PH_OFF     = 3'd0;
   localparam logic [2:0] PH_DELAY   = 3'd1;
   localparam logic [2:0] PH_ATTACK  = 3'd2;
   localparam logic [2:0] PH_HOLD    = 3'd3;
   localparam logic [2:0] PH_DECAY   = 3'd4;
   localparam logic [2:0] PH_SUSTAIN = 3'd5;
   localparam logic [2:0] PH_RELEASE = 3'd6;

   // Request kinds.
   localparam logic [1:0] KIND_TRIGGER = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_ADVANCE = 2'd2;

   // Register indexes.
   localparam logic [IDX_W-1:0] REG_DELAY   = 3'd0;
   localparam logic [IDX_W-1:0] REG_ATTACK  = 3'd1;
   localparam logic [IDX_W-1:0] REG_HOLD    = 3'd2;
   localparam logic [IDX_W-1:0] REG_DECAY   = 3'd3;
   localparam logic [IDX_W-1:0] REG_RELEASE = 3'd4;
   localparam logic [IDX_W-1:0] REG_SUSTAIN = 3'd5;

   // Datapath operations.
   localparam logic [3:0] OP_NOP       = 4'd0;
   localparam logic [3:0] OP_LATCH     = 4'd1;
   localparam logic [3:0] OP_ENTER     = 4'd2;
   localparam logic [3:0] OP_RELEASE   = 4'd3;
   localparam logic [3:0] OP_PARTIAL   = 4'd4;
   localparam logic [3:0] OP_MUL       = 4'd5;
   localparam logic [3:0] OP_DIV_START = 4'd6;
   localparam logic [3:0] OP_RAMP      = 4'd7;
   localparam logic [3:0] OP_XFER      = 4'd8;
   localparam logic [3:0] OP_FLAT      = 4'd9;
   localparam logic [3:0] OP_RESP      = 4'd10;

   // Jump conditions.
   localparam logic [3:0] C_NEXT     = 4'd0;
   localparam logic [3:0] C_ALWAYS   = 4'd1;
   localparam logic [3:0] C_REQ      = 4'd2;
   localparam logic [3:0] C_NO_STEPS = 4'd3;
   localparam logic [3:0] C_FLAT     = 4'd4;
   localparam logic [3:0] C_ENDS     = 4'd5;
   localparam logic [3:0] C_NO_RAMP  = 4'd6;
   localparam logic [3:0] C_DIV_DONE = 4'd7;
   localparam logic [3:0] C_OUT_FREE = 4'd8;

   // Microprogram addresses.
   localparam logic [UPC_W-1:0] U_IDLE      = 4'd0;
   localparam logic [UPC_W-1:0] U_TRIG      = 4'd1;
   localparam logic [UPC_W-1:0] U_REL       = 4'd2;
   localparam logic [UPC_W-1:0] U_ADV       = 4'd3;
   localparam logic [UPC_W-1:0] U_ADV_FLAT  = 4'd4;
   localparam logic [UPC_W-1:0] U_ADV_ENDS  = 4'd5;
   localparam logic [UPC_W-1:0] U_PARTIAL   = 4'd6;
   localparam logic [UPC_W-1:0] U_MUL       = 4'd7;
   localparam logic [UPC_W-1:0] U_DIV_START = 4'd8;
   localparam logic [UPC_W-1:0] U_DIV_WAIT  = 4'd9;
   localparam logic [UPC_W-1:0] U_RAMP      = 4'd10;
   localparam logic [UPC_W-1:0] U_XFER      = 4'd11;
   localparam logic [UPC_W-1:0] U_FLAT      = 4'd12;
   localparam logic [UPC_W-1:0] U_DONE      = 4'd13;

   // One control word: the operation, the jump condition, whether a false
   // condition holds the step counter instead of advancing it, and the target.
   typedef struct packed {
      logic [3:0]       op;
      logic [3:0]       cond;
      logic             hold;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [UPC_W-1:0] upc);
      ctrl_word_type w;
      case (upc)
         U_IDLE:      w = '{OP_LATCH,     C_REQ,      1'b1, U_IDLE};
         U_TRIG:      w = '{OP_ENTER,     C_ALWAYS,   1'b0, U_DONE};
         U_REL:       w = '{OP_RELEASE,   C_ALWAYS,   1'b0, U_DONE};
         U_ADV:       w = '{OP_NOP,       C_NO_STEPS, 1'b0, U_DONE};
         U_ADV_FLAT:  w = '{OP_NOP,       C_FLAT,     1'b0, U_FLAT};
         U_ADV_ENDS:  w = '{OP_NOP,       C_ENDS,     1'b0, U_XFER};
         U_PARTIAL:   w = '{OP_PARTIAL,   C_NO_RAMP,  1'b0, U_DONE};
         U_MUL:       w = '{OP_MUL,       C_NEXT,     1'b0, U_IDLE};
         U_DIV_START: w = '{OP_DIV_START, C_NEXT,     1'b0, U_IDLE};
         U_DIV_WAIT:  w = '{OP_NOP,       C_DIV_DONE, 1'b1, U_RAMP};
         U_RAMP:      w = '{OP_RAMP,      C_ALWAYS,   1'b0, U_DONE};
         U_XFER:      w = '{OP_XFER,      C_ALWAYS,   1'b0, U_ADV};
         U_FLAT:      w = '{OP_FLAT,      C_ALWAYS,   1'b0, U_DONE};
         U_DONE:      w = '{OP_RESP,      C_OUT_FREE, 1'b1, U_IDLE};
         default:     w = '{OP_NOP,       C_ALWAYS,   1'b0, U_IDLE};
      endcase
      return w;
   endfunction

   // First phase at or after 'from' whose length is not zero; nz holds the
   // non-zero flags of delay, attack, hold and decay in bits 0 to 3.
   function automatic logic [2:0] first_phase(input logic [2:0] from,
                                              input logic [3:0] nz);
      logic [2:0] ph;
      if (from <= PH_DELAY && nz[0]) begin
         ph = PH_DELAY;
      end else if (from <= PH_ATTACK && nz[1]) begin
         ph = PH_ATTACK;
      end else if (from <= PH_HOLD && nz[2]) begin
         ph = PH_HOLD;
      end else if (from <= PH_DECAY && nz[3]) begin
         ph = PH_DECAY;
      end else begin
         ph = PH_SUSTAIN;
      end
      return ph;
   endfunction

   // Sustain level (code * 32768 + 127) / 255. The code * 128 * 255 part is
   // split off, and the small rest is divided by 255 with the exact
   // reciprocal identity for 16-bit values.
   function automatic logic [LVL_W-1:0] sustain_q15(input logic [CODE_W-1:0] code);
      logic [LVL_W-1:0] base;
      logic [LVL_W-1:0] rest;
      logic [LVL_W:0]   t;
      base = {1'b0, code, 7'b0};
      rest = base + 16'd127;
      t    = {1'b0, rest} + {9'b0, rest[15:8]} + 17'd1;
      return base + {7'b0, t[16:8]};
   endfunction

endpackage

@@ hdl/dahdsr_divider.sv @@
// ----------------------------------------------------------------------------
// DAHDSR ramp divider
// Restoring divider, one quotient bit per cycle, for ramp numerators whose
// quotient is known to stay below 2^15.
// ----------------------------------------------------------------------------
module dahdsr_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dahdsr_pkg::PROD_W-1:0] numer,
   input  logic [dahdsr_pkg::LEN_W-1:0]  denom,
   output logic                         busy,
   output logic [dahdsr_pkg::Q_W-1:0]    quot
);
   import dahdsr_pkg::*;

   logic [LEN_W-1:0] rem_ff,  rem_in;
   logic [LEN_W-1:0] den_ff,  den_in;
   logic [Q_W-1:0]   bits_ff, bits_in;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;

   logic [LEN_W:0] trial;
   logic [LEN_W:0] diff;
   logic           fits;

   assign trial = {rem_ff, bits_ff[Q_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         // The numerator's upper part is already below the divisor.
         rem_in  = numer[Q_W+LEN_W-1:Q_W];
         bits_in = numer[Q_W-1:0];
         den_in  = denom;
         quot_in = '0;
         cnt_in  = CNT_W'(Q_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         bits_in = {bits_ff[Q_W-2:0], 1'b0};
         quot_in = {quot_ff[Q_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign busy = cnt_ff != '0;
   assign quot = quot_ff;

endmodule

@@ hdl/dahdsr_envelope_generator_top.sv @@
// ----------------------------------------------------------------------------
// DAHDSR envelope generator
// Linear delay-attack-hold-decay-sustain-release envelope run by a small
// microprogram; one response with level and phase for every request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   req_      in         req_valid / req_ready      req_kind, req_step_count
//   rsp_      out        rsp_valid / rsp_ready      rsp_level_out, rsp_phase_out
//   csr_      in         csr_write_en               csr_index, csr_wdata
//
// A trigger or a release loads its response at the final step, after its
// one datapath step. An advance runs a transfer step for every phase
// boundary it crosses, then a flat step when it ends in off or sustain, a
// counter step when it stops inside delay or hold, or a counter step, a
// multiply, the restoring divider and a ramp step when it stops inside a
// ramp. The worst case is three boundaries and a stop inside decay.
// Requests are taken one at a time: req_ready is high only while the
// microprogram waits at its idle step, entered as the response loads.
// The response register lets the next request in while a response waits;
// that request then stalls at the final step until rsp_ready frees the
// register. Reset clears the envelope to off and the registers to defaults.
//
module dahdsr_envelope_generator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [dahdsr_pkg::STEP_W-1:0] req_step_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dahdsr_pkg::LVL_W-1:0]  rsp_level_out,
   output logic [2:0]                    rsp_phase_out,
   input  logic                          csr_write_en,
   input  logic [dahdsr_pkg::IDX_W-1:0]  csr_index,
   input  logic [dahdsr_pkg::LEN_W-1:0]  csr_wdata
);
   import dahdsr_pkg::*;

   // Configuration registers.
   logic [LEN_W-1:0]  delay_len_ff, attack_len_ff, hold_len_ff;
   logic [LEN_W-1:0]  decay_len_ff, release_len_ff;
   logic [CODE_W-1:0] sustain_code_ff;

   // Sequencer and envelope state.
   logic [UPC_W-1:0]  upc_ff,       upc_in;
   logic [2:0]        phase_ff,     phase_in;
   logic [LEN_W-1:0]  count_ff,     count_in;
   logic [LVL_W-1:0]  level_ff,     level_in;
   logic [LVL_W-1:0]  rel_level_ff, rel_level_in;
   logic [STEP_W-1:0] steps_ff,     steps_in;
   logic [PROD_W-1:0] prod_ff,      prod_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [2:0]        rsp_phase_ff, rsp_phase_in;

   ctrl_word_type     cw;
   logic              req_accept;
   logic              out_free;
   logic              cond_true;
   logic [UPC_W-1:0]  dispatch;

   logic [3:0]        nz;
   logic [LVL_W-1:0]  sustain_lvl;
   logic [LEN_W-1:0]  len_cur;
   logic [LEN_W:0]    cnt_inc;
   logic [LEN_W-1:0]  need;
   logic              ends_here;
   logic [LVL_W-1:0]  mult_a;
   logic [2:0]        next_phase;

   logic              div_start;
   logic              div_busy;
   logic [Q_W-1:0]    div_quot;

   // The ramp level for the phase just entered.
   function automatic logic [LVL_W-1:0] entry_level(input logic [2:0] ph,
                                                   input logic [LVL_W-1:0] s);
      logic [LVL_W-1:0] lvl;
      case (ph)
         PH_HOLD, PH_DECAY: lvl = FULL_SCALE;
         PH_SUSTAIN:        lvl = s;
         default:           lvl = '0;
      endcase
      return lvl;
   endfunction

   // ------------------------------------------------------------------
   // Configuration writes; an index past the last register is dropped.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_len_ff    <= '0;
         attack_len_ff   <= '0;
         hold_len_ff     <= '0;
         decay_len_ff    <= '0;
         release_len_ff  <= '0;
         sustain_code_ff <= '1;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_DELAY:   delay_len_ff    <= csr_wdata;
            REG_ATTACK:  attack_len_ff   <= csr_wdata;
            REG_HOLD:    hold_len_ff     <= csr_wdata;
            REG_DECAY:   decay_len_ff    <= csr_wdata;
            REG_RELEASE: release_len_ff  <= csr_wdata;
            REG_SUSTAIN: sustain_code_ff <= csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Shared values derived from the state.
   // ------------------------------------------------------------------
   assign cw          = ucode_rom(upc_ff);
   assign req_ready   = upc_ff == U_IDLE;
   assign req_accept  = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign sustain_lvl = sustain_q15(sustain_code_ff);
   assign nz          = {decay_len_ff != '0, hold_len_ff != '0,
                         attack_len_ff != '0, delay_len_ff != '0};
   assign next_phase  = first_phase(phase_ff + 3'd1, nz);

   always_comb begin
      case (phase_ff)
         PH_DELAY:   len_cur = delay_len_ff;
         PH_ATTACK:  len_cur = attack_len_ff;
         PH_HOLD:    len_cur = hold_len_ff;
         PH_DECAY:   len_cur = decay_len_ff;
         PH_RELEASE: len_cur = release_len_ff;
         default:    len_cur = '0;
      endcase
   end

   // Samples left until the current phase ends. The counter stays below the
   // length, so it ends after exactly length - count more samples; a length
   // shrunk under the counter ends the phase on the next sample.
   assign cnt_inc   = {1'b0, count_ff} + 1'b1;
   assign need      = (cnt_inc >= {1'b0, len_cur}) ? LEN_W'(1) : len_cur - count_ff;
   assign ends_here = {{(LEN_W-STEP_W){1'b0}}, steps_ff} >= need;

   // Ramp slope numerator: the span that the ramp covers over its length.
   always_comb begin
      case (phase_ff)
         PH_ATTACK:  mult_a = FULL_SCALE;
         PH_DECAY:   mult_a = FULL_SCALE - sustain_lvl;
         default:    mult_a = rel_level_ff;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: conditional jump, hold, or step to the next control word.
   // ------------------------------------------------------------------
   always_comb begin
      case (req_kind)
         KIND_TRIGGER: dispatch = U_TRIG;
         KIND_RELEASE: dispatch = U_REL;
         KIND_ADVANCE: dispatch = U_ADV;
         default:      dispatch = U_DONE;
      endcase

      case (cw.cond)
         C_ALWAYS:   cond_true = 1'b1;
         C_REQ:      cond_true = req_valid;
         C_NO_STEPS: cond_true = steps_ff == '0;
         C_FLAT:     cond_true = phase_ff inside {PH_OFF, PH_SUSTAIN};
         C_ENDS:     cond_true = ends_here;
         C_NO_RAMP:  cond_true = phase_ff inside {PH_DELAY, PH_HOLD};
         C_DIV_DONE: cond_true = !div_busy;
         C_OUT_FREE: cond_true = out_free;
         default:    cond_true = 1'b0;
      endcase

      if (cond_true) begin
         upc_in = (cw.cond == C_REQ) ? dispatch : cw.target;
      end else if (cw.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Datapath driven by the control word's operation field.
   // ------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      level_in     = level_ff;
      rel_level_in = rel_level_ff;
      steps_in     = steps_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;
      rsp_phase_in = rsp_phase_ff;
      div_start    = 1'b0;

      case (cw.op)
         OP_LATCH: begin
            if (req_accept) begin
               steps_in = req_step_count;
            end
         end
         OP_ENTER: begin
            phase_in = first_phase(PH_DELAY, nz);
            count_in = '0;
            level_in = entry_level(first_phase(PH_DELAY, nz), sustain_lvl);
         end
         OP_RELEASE: begin
            // A release while off or already releasing is ignored.
            if (phase_ff != PH_OFF && phase_ff != PH_RELEASE) begin
               rel_level_in = level_ff;
               count_in     = '0;
               if (release_len_ff == '0) begin
                  phase_in = PH_OFF;
                  level_in = '0;
               end else begin
                  phase_in = PH_RELEASE;
               end
            end
         end
         OP_PARTIAL: begin
            // The advance stops inside this phase: move the counter. Hold sets full
            // scale, delay keeps its level, and a ramp leaves it to the ramp steps.
            count_in = count_ff + {{(LEN_W-STEP_W){1'b0}}, steps_ff};
            steps_in = '0;
            if (phase_ff == PH_HOLD) begin
               level_in = FULL_SCALE;
            end
         end
         OP_MUL: begin
            prod_in = PROD_W'(mult_a) * PROD_W'(count_ff);
         end
         OP_DIV_START: begin
            div_start = 1'b1;
         end
         OP_RAMP: begin
            case (phase_ff)
               PH_ATTACK: level_in = {1'b0, div_quot};
               PH_DECAY:  level_in = FULL_SCALE - {1'b0, div_quot};
               default:   level_in = rel_level_ff - {1'b0, div_quot};
            endcase
         end
         OP_XFER: begin
            // The advance runs through to the end of the phase.
            steps_in = steps_ff - need[STEP_W-1:0];
            count_in = '0;
            if (phase_ff == PH_RELEASE) begin
               phase_in = PH_OFF;
               level_in = '0;
            end else begin
               phase_in = next_phase;
               level_in = entry_level(next_phase, sustain_lvl);
            end
         end
         OP_FLAT: begin
            // Off holds zero, sustain follows the current sustain code.
            level_in = (phase_ff == PH_SUSTAIN) ? sustain_lvl : '0;
            steps_in = '0;
         end
         OP_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_phase_in = phase_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= U_IDLE;
         phase_ff     <= PH_OFF;
         count_ff     <= '0;
         level_ff     <= '0;
         rel_level_ff <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         level_ff     <= level_in;
         rel_level_ff <= rel_level_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff      <= prod_in;
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   dahdsr_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (prod_ff),
      .denom (len_cur),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level_out = rsp_level_ff;
   assign rsp_phase_out = rsp_phase_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The level never goes above full scale.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= FULL_SCALE)
      else $error("envelope level above full scale");

   // Once off, the envelope sits at zero whenever the sequencer is idle.
   a_off_is_zero: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_IDLE && phase_ff == PH_OFF) |-> level_ff == '0)
      else $error("level not zero while off");

   // The divider is never left running when a new request can come in.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == U_IDLE) |-> !div_busy)
      else $error("divider busy at idle step");

   // A new response only appears from the final microprogram step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff) == U_DONE)
      else $error("response loaded outside the final step");

endmodule
